### rtl/nssa_pkg.sv
// ----------------------------------------------------------------------------
// nssa_pkg
// Types and codes shared by the nested scope stack allocator: request and
// result items, the scope table entry, action and status codes.
// ----------------------------------------------------------------------------
package nssa_pkg;

	localparam int VAL_W         = 17;
	localparam int ADDR_BITS     = 16;
	localparam int MAX_DEPTH_DEF = 16;

	localparam logic [VAL_W-1:0] POOL_LIMIT     = VAL_W'(64'd1 << ADDR_BITS);
	localparam logic [VAL_W-1:0] POOL_SIZE_RST  = 17'd65536;

	// action codes
	localparam logic [2:0] ACT_OPEN   = 3'd0;
	localparam logic [2:0] ACT_CLOSE  = 3'd1;
	localparam logic [2:0] ACT_LINEAR = 3'd2;
	localparam logic [2:0] ACT_UNIQUE = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;

	// status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NOSPACE = 3'd1;
	localparam logic [2:0] ST_NOLEVEL = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_EMPTY   = 3'd4;

	typedef struct packed {
		logic [2:0]       action;
		logic [3:0]       level;
		logic [VAL_W-1:0] size;
		logic [VAL_W-1:0] reserve;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [VAL_W-1:0] offset;
		logic [4:0]       open_scopes;
	} rsp_t;

	typedef struct packed {
		logic [VAL_W-1:0] start;
		logic [VAL_W-1:0] used;
		logic [VAL_W-1:0] cap;
	} scope_t;

endpackage

### rtl/nssa_ram.sv
// ----------------------------------------------------------------------------
// nssa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nssa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

### rtl/nested_scope_stack_allocator.sv
// ----------------------------------------------------------------------------
// nested_scope_stack_allocator
// Linear pool handed out through a stack of nested scopes. Scope entries
// (start, used, capacity) live in one RAM; a small sequencer reads, updates
// and writes them back for each request item.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        input      in_valid / in_ready     in_data  (req_t)
//  out       output     out_valid / out_ready   out_data (rsp_t)
//  cfg       input      cfg_wr_en               cfg_wr_data (pool size)
//
//  One item at a time: the next item is taken only after the result of the
//  last one is loaded into the result register. Opening a nested scope or
//  closing one above the outermost reads the top entry, then does two
//  writes, or a second read and a write-back; alloc and clear read, then
//  modify and write; items settled from the open count alone go straight
//  to the result.
//  The result sits in an output register, so a stalled out channel only holds
//  back the item after the next one. Reset empties the stack; RAM contents
//  need no clearing since only opened entries are read.
// ----------------------------------------------------------------------------
module nested_scope_stack_allocator
	import nssa_pkg::*;
#(
	parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [VAL_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  req_t             in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output rsp_t             out_data
);

	localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int CNT_W = $clog2(MAX_DEPTH + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ISSUE  = 3'd1;
	localparam logic [2:0] S_FIRST  = 3'd2;
	localparam logic [2:0] S_SECOND = 3'd3;
	localparam logic [2:0] S_WB     = 3'd4;
	localparam logic [2:0] S_RESP   = 3'd5;

	logic [2:0]       state_q;
	logic [VAL_W-1:0] pool_size_q;
	logic [CNT_W-1:0] count_q;
	req_t             req_q;
	logic [2:0]       status_q;
	logic [VAL_W-1:0] offset_q;
	scope_t           wb_q;
	logic [IDX_W-1:0] wb_addr_q;
	logic [VAL_W-1:0] child_cap_q;
	logic             out_valid_q;
	rsp_t             out_q;

	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	scope_t           wr_data;
	logic [IDX_W-1:0] rd_addr;
	scope_t           rd_data;

	logic [IDX_W-1:0] top_idx;
	logic [IDX_W-1:0] lvl_idx;
	logic [IDX_W-1:0] new_idx;
	logic             level_bad;
	logic             stack_full;
	logic [VAL_W-1:0] pool_clamp;

	logic [VAL_W-1:0] avail;
	logic [VAL_W-1:0] keep;
	logic [VAL_W-1:0] child_start;
	logic [VAL_W:0]   lin_next;
	logic             lin_fit;
	logic             uni_fit;
	logic [VAL_W-1:0] lin_offset;
	logic             out_free;

	nssa_ram #(
		.WIDTH ($bits(scope_t)),
		.DEPTH (MAX_DEPTH)
	) u_scope_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign top_idx    = IDX_W'(count_q - CNT_W'(1));
	assign new_idx    = IDX_W'(count_q);
	assign lvl_idx    = IDX_W'(req_q.level);
	assign level_bad  = 8'(req_q.level) >= 8'(count_q);
	assign stack_full = count_q == CNT_W'(MAX_DEPTH);
	assign pool_clamp = (pool_size_q > POOL_LIMIT) ? POOL_LIMIT : pool_size_q;

	// scope arithmetic on the entry just read
	assign avail       = (rd_data.cap > rd_data.used) ? rd_data.cap - rd_data.used : '0;
	assign keep        = (req_q.reserve < avail) ? req_q.reserve : avail;
	assign child_start = rd_data.start + rd_data.used + keep;
	assign lin_next    = {1'b0, rd_data.used} + {1'b0, req_q.size};
	assign lin_fit     = lin_next <= {1'b0, rd_data.cap};
	assign uni_fit     = req_q.size <= rd_data.cap;
	assign lin_offset  = rd_data.start + rd_data.used;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		rd_addr = top_idx;
		wr_en   = 1'b0;
		wr_addr = top_idx;
		wr_data = rd_data;
		unique case (state_q)
			S_ISSUE: begin
				if (req_q.action == ACT_OPEN || req_q.action == ACT_CLOSE) begin
					rd_addr = top_idx;
				end else begin
					rd_addr = lvl_idx;
				end
				// outermost open needs no read
				if (req_q.action == ACT_OPEN && count_q == '0) begin
					wr_en   = 1'b1;
					wr_addr = '0;
					wr_data = '{start: '0, used: '0, cap: pool_clamp};
				end
			end
			S_FIRST: begin
				rd_addr = top_idx - IDX_W'(1);
				unique case (req_q.action)
					ACT_OPEN: begin
						wr_en   = 1'b1;
						wr_addr = new_idx;
						wr_data = '{start: child_start, used: '0, cap: avail - keep};
					end
					ACT_LINEAR: begin
						wr_en        = lin_fit;
						wr_addr      = lvl_idx;
						wr_data.used = lin_next[VAL_W-1:0];
					end
					ACT_UNIQUE: begin
						wr_en        = uni_fit;
						wr_addr      = lvl_idx;
						wr_data.used = req_q.size;
					end
					ACT_CLEAR: begin
						wr_en        = 1'b1;
						wr_addr      = lvl_idx;
						wr_data.used = '0;
					end
					default: begin
						wr_en = 1'b0;
					end
				endcase
			end
			S_SECOND: begin
				// parent of the closed scope takes back its capacity
				wr_en       = 1'b1;
				wr_addr     = top_idx - IDX_W'(1);
				wr_data.cap = rd_data.cap + child_cap_q;
			end
			S_WB: begin
				wr_en   = 1'b1;
				wr_addr = wb_addr_q;
				wr_data = wb_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pool_size_q <= POOL_SIZE_RST;
			count_q     <= '0;
			status_q    <= ST_OK;
			offset_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				pool_size_q <= cfg_wr_data;
			end
			// load a new result, or drop the one just taken
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q  <= S_ISSUE;
						status_q <= ST_OK;
						offset_q <= '0;
					end
				end
				S_ISSUE: begin
					unique case (req_q.action)
						ACT_OPEN: begin
							if (stack_full) begin
								status_q <= ST_FULL;
								state_q  <= S_RESP;
							end else if (count_q == '0) begin
								count_q <= CNT_W'(1);
								state_q <= S_RESP;
							end else begin
								state_q <= S_FIRST;
							end
						end
						ACT_CLOSE: begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
								state_q  <= S_RESP;
							end else if (count_q == CNT_W'(1)) begin
								count_q <= '0;
								state_q <= S_RESP;
							end else begin
								state_q <= S_FIRST;
							end
						end
						ACT_LINEAR, ACT_UNIQUE, ACT_CLEAR: begin
							if (level_bad) begin
								status_q <= ST_NOLEVEL;
								state_q  <= S_RESP;
							end else begin
								state_q <= S_FIRST;
							end
						end
						default: begin
							state_q <= S_RESP;
						end
					endcase
				end
				S_FIRST: begin
					unique case (req_q.action)
						ACT_OPEN: begin
							wb_q      <= '{start: rd_data.start, used: rd_data.used,
							               cap: rd_data.used + keep};
							wb_addr_q <= top_idx;
							offset_q  <= child_start;
							count_q   <= count_q + CNT_W'(1);
							state_q   <= S_WB;
						end
						ACT_CLOSE: begin
							child_cap_q <= rd_data.cap;
							state_q     <= S_SECOND;
						end
						ACT_LINEAR: begin
							state_q <= S_RESP;
							if (lin_fit) begin
								offset_q <= lin_offset;
							end else begin
								status_q <= ST_NOSPACE;
							end
						end
						ACT_UNIQUE: begin
							state_q <= S_RESP;
							if (uni_fit) begin
								offset_q <= rd_data.start;
							end else begin
								status_q <= ST_NOSPACE;
							end
						end
						default: begin
							state_q <= S_RESP;
						end
					endcase
				end
				S_SECOND: begin
					count_q <= count_q - CNT_W'(1);
					state_q <= S_RESP;
				end
				S_WB: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					// hold the result until the output register frees up
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q    <= in_data;
		end
		if (state_q == S_RESP && out_free) begin
			out_q <= '{status: status_q, offset: offset_q,
			           open_scopes: 5'(count_q)};
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
